>>> design/iqmb_pkg.sv
// ----------------------------------------------------------------------------
// iqmb_pkg
// Shared types, constants and the 8-bit float encoder of the IGMP message
// builder.
// ----------------------------------------------------------------------------
package iqmb_pkg;

    localparam logic [7:0]  MEMBERSHIP_QUERY = 8'h11;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned SUM_W      = 19;   // six 16-bit halves
    localparam int unsigned MAX_WORDS  = 3;
    localparam int unsigned WIDX_W     = 2;

    localparam int unsigned IN_DATA_W  = 56;   // type, code, group
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [2:0]  ROBUSTNESS_RST     = 3'd2;
    localparam logic [15:0] QUERY_INTERVAL_RST = 16'd125;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_ROBUSTNESS     = 1'b0,
        REG_QUERY_INTERVAL = 1'b1
    } reg_idx_t;

    typedef logic [WORD_W-1:0] word_t;

    // RFC 3376 code: below 128 as is, else 1 eee mmmm (mantissa truncated).
    // The value is taken modulo 32768 first.
    function automatic logic [7:0] float_code(input logic [15:0] v);
        logic [14:0] m;
        logic [11:0] t;
        logic [7:0]  e;
        m = v[14:0];
        t = m[14:3];
        e = 8'h80;
        if (m[14:7] == 8'd0)
        begin
            return {1'b0, m[6:0]};
        end
        if (t[11:8] != 4'd0)
        begin
            t = t >> 4;
            e = e | 8'h40;
        end
        if (t[7:6] != 2'd0)
        begin
            t = t >> 2;
            e = e | 8'h20;
        end
        if (t[5])
        begin
            t = t >> 1;
            e = e | 8'h10;
        end
        return e | {4'd0, t[3:0]};
    endfunction

endpackage

>>> design/igmp_query_message_builder_unit.sv
// ----------------------------------------------------------------------------
// igmp_query_message_builder_unit
// Builds an IGMP message (8-byte form or 12-byte IGMPv3 query) with its
// Internet checksum and sends it as 32-bit big-endian words.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                  | content
//  ---------+-----+----------------------------+---------------------------------
//  s_axis   | in  | tvalid/tready              | tdata: type, code, group; tuser: ext
//  m_axis   | out | tvalid/tready, tlast       | tdata: wire word, tlast: last word
//  apb      | in  | psel/penable/pwrite/pready | robustness @0x0, query_interval @0x4
//
//  An accepted request passes three register stages (capture, encode,
//  halves sum) and lands in the word serializer, which folds the sum and
//  inserts the checksum on load. The serializer sets the rate: a plain
//  message is 2 words, an IGMPv3 query 3; a new message loads in the
//  cycle its predecessor's last beat goes. Stalls back up via stage valid
//  bits; rst_n clears them, reloads config.
//
module igmp_query_message_builder_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] msg_type, [23:8] code_value, [55:24] group_addr
    input  logic [iqmb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] extended_query
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] wire_word
    output logic [iqmb_pkg::WORD_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iqmb_pkg::PADDR_W-1:0]       paddr,
    input  logic [iqmb_pkg::PDATA_W-1:0]       pwdata,
    output logic [iqmb_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  robustness_reg;
    logic [15:0] query_interval_reg;
    logic        cfg_wr;
    iqmb_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = iqmb_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robustness_reg     <= iqmb_pkg::ROBUSTNESS_RST;
            query_interval_reg <= iqmb_pkg::QUERY_INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                iqmb_pkg::REG_ROBUSTNESS:     robustness_reg     <= pwdata[2:0];
                iqmb_pkg::REG_QUERY_INTERVAL: query_interval_reg <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            iqmb_pkg::REG_ROBUSTNESS:     prdata = {29'd0, robustness_reg};
            iqmb_pkg::REG_QUERY_INTERVAL: prdata = {16'd0, query_interval_reg};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage advances when the next one has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, ser_valid_reg;
    logic s1_ready, s2_ready, s3_ready, ser_ready;
    logic ser_last;

    assign ser_ready     = !ser_valid_reg || (m_axis_tready && ser_last);
    assign s3_ready      = !s3_valid_reg || ser_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: capture the request
    // ------------------------------------------------------------------
    logic [7:0]  s1_type_reg;
    logic [15:0] s1_code_reg;
    logic [31:0] s1_group_reg;
    logic        s1_ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_type_reg  <= s_axis_tdata[7:0];
            s1_code_reg  <= s_axis_tdata[23:8];
            s1_group_reg <= s_axis_tdata[55:24];
            s1_ext_reg   <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the form, float-encode, lay out the words
    // ------------------------------------------------------------------
    iqmb_pkg::word_t s2_word_reg [iqmb_pkg::MAX_WORDS];
    logic            s2_v3_reg;
    iqmb_pkg::word_t s2_word_next [iqmb_pkg::MAX_WORDS];
    logic            s2_v3_next;
    logic [7:0]      s2_code;

    always_comb
    begin
        s2_v3_next = s1_ext_reg && (s1_type_reg == iqmb_pkg::MEMBERSHIP_QUERY);
        s2_code    = s2_v3_next ? iqmb_pkg::float_code(s1_code_reg) : s1_code_reg[7:0];
        s2_word_next[0] = {s1_type_reg, s2_code, 16'd0};
        s2_word_next[1] = s1_group_reg;
        s2_word_next[2] = s2_v3_next
                        ? {5'd0, robustness_reg,
                           iqmb_pkg::float_code(query_interval_reg), 16'd0}
                        : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg <= s2_word_next;
            s2_v3_reg   <= s2_v3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum the 16-bit halves (unused third word is zero)
    // ------------------------------------------------------------------
    iqmb_pkg::word_t              s3_word_reg [iqmb_pkg::MAX_WORDS];
    logic                         s3_v3_reg;
    logic [iqmb_pkg::SUM_W-1:0]   s3_sum_reg;
    logic [iqmb_pkg::SUM_W-1:0]   s3_sum_next;

    always_comb
    begin
        s3_sum_next = 19'(s2_word_reg[0][31:16]) + 19'(s2_word_reg[0][15:0])
                    + 19'(s2_word_reg[1][31:16]) + 19'(s2_word_reg[1][15:0])
                    + 19'(s2_word_reg[2][31:16]) + 19'(s2_word_reg[2][15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_word_reg <= s2_word_reg;
            s3_v3_reg   <= s2_v3_reg;
            s3_sum_reg  <= s3_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Serializer: fold the sum, insert the checksum, send word by word
    // ------------------------------------------------------------------
    iqmb_pkg::word_t              ser_word_reg [iqmb_pkg::MAX_WORDS];
    logic [iqmb_pkg::WIDX_W-1:0]  ser_idx_reg;
    logic [iqmb_pkg::WIDX_W-1:0]  ser_end_reg;
    logic [16:0]                  fold1;
    logic [16:0]                  fold2;
    logic [15:0]                  csum;

    always_comb
    begin
        fold1 = 17'(s3_sum_reg[15:0]) + 17'(s3_sum_reg[18:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
        csum  = ~fold2[15:0];
    end

    assign ser_last = (ser_idx_reg == ser_end_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
            ser_end_reg   <= '0;
        end
        else if (ser_ready)
        begin
            // Load the next message (or go empty) when empty or once the last beat leaves
            ser_valid_reg <= s3_valid_reg;
            ser_idx_reg   <= '0;
            ser_end_reg   <= s3_v3_reg ? 2'd2 : 2'd1;
        end
        else if (m_axis_tready)
        begin
            // Advance to the next word of the message
            ser_idx_reg <= ser_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_ready && s3_valid_reg)
        begin
            ser_word_reg[0] <= {s3_word_reg[0][31:16], csum};
            ser_word_reg[1] <= s3_word_reg[1];
            ser_word_reg[2] <= s3_word_reg[2];
        end
    end

    assign m_axis_tvalid = ser_valid_reg;
    assign m_axis_tdata  = ser_word_reg[ser_idx_reg];
    assign m_axis_tlast  = ser_last;

endmodule

>>> design/iqmb_checker.sv
// ----------------------------------------------------------------------------
// iqmb_checker
// Port-level checks of the IGMP message builder: beat stability, pready,
// reset behavior and message length.
// ----------------------------------------------------------------------------
module iqmb_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [iqmb_pkg::WORD_W-1:0]    m_axis_tdata,
    input  logic                           m_axis_tlast,
    input  logic                           pready
);

    // Beats of the current message already accepted
    logic [1:0] beat_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            beat_cnt_reg <= m_axis_tlast ? 2'd0 : beat_cnt_reg + 2'd1;
        end
    end

    // Hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // No output beat while in reset
    a_rst: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // A message has at least two words
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && beat_cnt_reg == 2'd0 |-> !m_axis_tlast)
        else $error("message ended after one word");

    // A message has at most three words
    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && beat_cnt_reg == 2'd2 |-> m_axis_tlast)
        else $error("message longer than three words");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind igmp_query_message_builder_unit iqmb_checker u_iqmb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
